/* rtl/packet_gap_fill_sequencer_macros.svh */
// ---------------------------------------------------------------------------
// packet_gap_fill_sequencer assertion macros
// shared concurrent assertion forms for the sequencer checker
// ---------------------------------------------------------------------------
`ifndef PACKET_GAP_FILL_SEQUENCER_MACROS_SVH
`define PACKET_GAP_FILL_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PGFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PGFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pgfs_pkg.sv */
// ---------------------------------------------------------------------------
// pgfs_pkg
// sizes, command codes and the front-to-back descriptor of the sequencer
// ---------------------------------------------------------------------------
package pgfs_pkg;

    // geometry of the capture buffers
    localparam int SLOTS_PER_BUFFER  = 1024;
    // packets per spectrum, a power of two (position taken as a mask)
    localparam int PKTS_PER_SPECTRUM = 2;
    localparam int NUM_BUFFERS       = 4;

    // fixed field widths
    localparam int COUNTER_W = 56;
    localparam int SOURCE_W  = 8;
    localparam int ACTION_W  = 3;
    localparam int BUFIDX_W  = 2;
    localparam int OFFSET_W  = 10;
    localparam int COUNT_W   = 11;
    localparam int BEAM_W    = 5;
    localparam int MISSED_W  = 32;

    // derived internal widths
    localparam int SLOT_W = $clog2(SLOTS_PER_BUFFER);
    localparam int ROOM_W = $clog2(SLOTS_PER_BUFFER + 1);
    localparam int SEQ_W  = (PKTS_PER_SPECTRUM > 1) ? $clog2(PKTS_PER_SPECTRUM) : 1;
    localparam int GAP_W  = $clog2(PKTS_PER_SPECTRUM + 1);
    localparam int LIM_W  = ((ROOM_W > GAP_W) ? ROOM_W : GAP_W) + 1;
    localparam int BUF_W  = $clog2(NUM_BUFFERS);

    // descriptor queue
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 3'd0,
        ACT_FILL  = 3'd1,
        ACT_FULL  = 3'd2,
        ACT_DROP  = 3'd3,
        ACT_GAP   = 3'd4
    } action_t;

    // command run that one header expands into
    typedef enum logic [2:0] {
        K_WRITE,
        K_WRITE_FULL,
        K_FILL,
        K_FILL_FULL,
        K_FILL_FULL_FILL,
        K_GAP,
        K_DROP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [BUFIDX_W-1:0]     buf_idx;
        logic [BUFIDX_W-1:0]     next_buf;
        logic [OFFSET_W-1:0]     offset;
        logic [COUNT_W-1:0]      count_a;
        logic [COUNT_W-1:0]      count_b;
        logic [SOURCE_W-1:0]     source;
        logic [MISSED_W-1:0]     missed;
    } desc_t;

    typedef struct packed {
        logic              empty;
        logic [QLVL_W-1:0] level;
    } fifo_status_t;

endpackage

/* rtl/pgfs_hdr_if.sv */
// ---------------------------------------------------------------------------
// pgfs_hdr_if
// packet header channel: counter and source byte with valid/ready
// ---------------------------------------------------------------------------
interface pgfs_hdr_if import pgfs_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [COUNTER_W-1:0] packet_counter;
    logic [SOURCE_W-1:0]  source_byte;

    modport source (output valid, output packet_counter, output source_byte, input ready);
    modport sink   (input valid, input packet_counter, input source_byte, output ready);

endinterface

/* rtl/pgfs_cmd_if.sv */
// ---------------------------------------------------------------------------
// pgfs_cmd_if
// buffer command channel with decoded source bits and missed total
// ---------------------------------------------------------------------------
interface pgfs_cmd_if import pgfs_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BUFIDX_W-1:0] buffer_index;
    logic [OFFSET_W-1:0] slot_offset;
    logic [COUNT_W-1:0]  slot_count;
    logic [BEAM_W-1:0]   beam_number;
    logic                cross_term;
    logic                adc_source;
    logic                multi_beam;
    logic [MISSED_W-1:0] missed_total;
    logic                last;

    modport source (
        output valid, output action, output buffer_index, output slot_offset,
        output slot_count, output beam_number, output cross_term, output adc_source,
        output multi_beam, output missed_total, output last,
        input ready
    );
    modport sink (
        input valid, input action, input buffer_index, input slot_offset,
        input slot_count, input beam_number, input cross_term, input adc_source,
        input multi_beam, input missed_total, input last,
        output ready
    );

endinterface

/* rtl/pgfs_fifo.sv */
// ---------------------------------------------------------------------------
// pgfs_fifo
// short descriptor queue between the classifying front and the command back
// ---------------------------------------------------------------------------
module pgfs_fifo import pgfs_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  desc_t        push_desc,
    input  logic         pop,
    output desc_t        head,
    output fifo_status_t status
);

    desc_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QLVL_W-1:0] level_reg, level_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg + QLVL_W'(push) - QLVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.empty = (level_reg == '0);
    assign status.level = level_reg;

endmodule

/* rtl/pgfs_front.sv */
// ---------------------------------------------------------------------------
// pgfs_front
// header decode, sequence tracking and gap classification, one header a cycle while the queue has room
// ---------------------------------------------------------------------------
module pgfs_front import pgfs_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    pgfs_hdr_if.sink     hdr,
    input  fifo_status_t fifo_st,
    output logic         push,
    output desc_t        push_desc
);

    // decode stage
    logic                 s1_valid_reg;
    logic [COUNTER_W-1:0] s1_cnt_reg;
    logic [SOURCE_W-1:0]  s1_src_reg;
    logic                 s1_seq_zero_reg;
    logic [GAP_W-1:0]     s1_gap_reg;
    logic [COUNTER_W-1:0] s1_bound_reg;
    logic [COUNTER_W-1:0] s1_inc_reg;

    // classify stage
    logic                 s2_valid_reg;
    desc_t                s2_desc_reg, s2_desc_next;
    logic                 s2_miss_reg, s2_miss_next;
    logic                 s2_diff_hi_reg, s2_diff_hi_next;
    logic [MISSED_W-1:0]  s2_diff_lo_reg, s2_diff_lo_next;

    // accounting stage, feeds the queue
    logic                 push_reg;
    desc_t                push_desc_reg, push_desc_next;

    // sequence state
    logic [COUNTER_W-1:0] exp_reg, exp_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [BUF_W-1:0]     cur_buf_reg, cur_buf_next;
    logic                 in_spec_reg, in_spec_next;
    logic                 started_reg, started_next;
    logic [MISSED_W-1:0]  missed_reg, missed_next;

    logic                 accept;
    logic [QLVL_W+1:0]    in_flight;
    logic [SEQ_W-1:0]     seq;
    logic [GAP_W-1:0]     gap;

    function automatic logic [BUF_W-1:0] buf_after(input logic [BUF_W-1:0] b);
        return (b == BUF_W'(NUM_BUFFERS - 1)) ? '0 : b + BUF_W'(1);
    endfunction

    // room is reserved for every header in the pipe, so the pipe never stalls
    always_comb
    begin
        in_flight = (QLVL_W+2)'(fifo_st.level) + (QLVL_W+2)'(s1_valid_reg)
                  + (QLVL_W+2)'(s2_valid_reg) + (QLVL_W+2)'(push_reg);
    end

    assign hdr.ready = (in_flight < (QLVL_W+2)'(QDEPTH));
    assign accept    = hdr.valid && hdr.ready;

    // position within spectrum and distance to the next boundary
    assign seq = hdr.packet_counter[SEQ_W-1:0] & SEQ_W'(PKTS_PER_SPECTRUM - 1);
    assign gap = GAP_W'(PKTS_PER_SPECTRUM) - GAP_W'(seq);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cnt_reg      <= hdr.packet_counter;
            s1_src_reg      <= hdr.source_byte;
            s1_seq_zero_reg <= (seq == '0);
            s1_gap_reg      <= gap;
            s1_bound_reg    <= hdr.packet_counter + COUNTER_W'(gap);
            s1_inc_reg      <= hdr.packet_counter + COUNTER_W'(1);
        end
    end

    // classification against the sequence state
    always_comb
    begin
        logic                 take;
        logic                 match;
        logic [COUNTER_W-1:0] diff;
        logic [ROOM_W-1:0]    ws_inc;
        logic [LIM_W-1:0]     room_l;
        logic [LIM_W-1:0]     gap_l;
        logic [LIM_W-1:0]     slots_l;
        logic [LIM_W-1:0]     span_l;
        logic [LIM_W-1:0]     rest_l;
        logic                 fits;
        logic                 one_buf;

        take    = s1_seq_zero_reg || in_spec_reg;
        match   = !started_reg || (s1_cnt_reg == exp_reg);
        diff    = s1_cnt_reg - exp_reg;
        ws_inc  = ROOM_W'(slot_reg) + ROOM_W'(1);
        room_l  = LIM_W'(SLOTS_PER_BUFFER) - LIM_W'(slot_reg);
        gap_l   = LIM_W'(s1_gap_reg);
        slots_l = LIM_W'(SLOTS_PER_BUFFER);
        span_l  = diff[LIM_W-1:0] + gap_l;
        rest_l  = span_l - room_l;
        // span below room, and span within one buffer, both moved onto diff
        fits    = (room_l > gap_l) && (diff < COUNTER_W'(room_l - gap_l));
        one_buf = (slots_l >= gap_l) && (diff <= COUNTER_W'(slots_l - gap_l));

        exp_next     = exp_reg;
        slot_next    = slot_reg;
        cur_buf_next = cur_buf_reg;
        in_spec_next = in_spec_reg;
        started_next = started_reg;

        s2_desc_next          = '0;
        s2_desc_next.kind     = K_DROP;
        s2_desc_next.buf_idx  = BUFIDX_W'(cur_buf_reg);
        s2_desc_next.next_buf = BUFIDX_W'(buf_after(cur_buf_reg));
        s2_desc_next.offset   = OFFSET_W'(slot_reg);
        s2_desc_next.source   = s1_src_reg;
        s2_miss_next          = 1'b0;
        s2_diff_hi_next       = |diff[COUNTER_W-1:MISSED_W];
        s2_diff_lo_next       = diff[MISSED_W-1:0];

        if (s1_valid_reg && take)
        begin
            started_next = 1'b1;
            if (match)
            begin
                exp_next             = s1_inc_reg;
                s2_desc_next.count_a = COUNT_W'(1);
                if (ws_inc == ROOM_W'(SLOTS_PER_BUFFER))
                begin
                    s2_desc_next.kind = K_WRITE_FULL;
                    slot_next         = '0;
                    cur_buf_next      = buf_after(cur_buf_reg);
                    in_spec_next      = 1'b0;
                end
                else
                begin
                    s2_desc_next.kind = K_WRITE;
                    slot_next         = ws_inc[SLOT_W-1:0];
                    in_spec_next      = 1'b1;
                end
            end
            else
            begin
                s2_miss_next = 1'b1;
                exp_next     = s1_bound_reg;
                in_spec_next = 1'b0;
                priority if (fits)
                begin
                    s2_desc_next.kind    = K_FILL;
                    s2_desc_next.count_a = COUNT_W'(span_l);
                    slot_next            = slot_reg + span_l[SLOT_W-1:0];
                end
                else if (one_buf)
                begin
                    s2_desc_next.kind    = (rest_l == '0) ? K_FILL_FULL : K_FILL_FULL_FILL;
                    s2_desc_next.count_a = COUNT_W'(room_l);
                    s2_desc_next.count_b = COUNT_W'(rest_l);
                    slot_next            = rest_l[SLOT_W-1:0];
                    cur_buf_next         = buf_after(cur_buf_reg);
                end
                else
                begin
                    s2_desc_next.kind = K_GAP;
                end
            end
        end
    end

    // saturating missed-packet total
    always_comb
    begin
        logic [MISSED_W:0] sum;
        logic              sat;

        sum = {1'b0, missed_reg} + {1'b0, s2_diff_lo_reg};
        sat = s2_diff_hi_reg || (sum >= (MISSED_W+1)'({MISSED_W{1'b1}}));

        missed_next = missed_reg;
        if (s2_valid_reg && s2_miss_reg)
        begin
            missed_next = sat ? {MISSED_W{1'b1}} : sum[MISSED_W-1:0];
        end
        push_desc_next        = s2_desc_reg;
        push_desc_next.missed = missed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            push_reg     <= 1'b0;
            exp_reg      <= '0;
            slot_reg     <= '0;
            cur_buf_reg  <= '0;
            in_spec_reg  <= 1'b0;
            started_reg  <= 1'b0;
            missed_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            push_reg     <= s2_valid_reg;
            exp_reg      <= exp_next;
            slot_reg     <= slot_next;
            cur_buf_reg  <= cur_buf_next;
            in_spec_reg  <= in_spec_next;
            started_reg  <= started_next;
            missed_reg   <= missed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_desc_reg    <= s2_desc_next;
        s2_miss_reg    <= s2_miss_next;
        s2_diff_hi_reg <= s2_diff_hi_next;
        s2_diff_lo_reg <= s2_diff_lo_next;
        push_desc_reg  <= push_desc_next;
    end

    assign push      = push_reg;
    assign push_desc = push_desc_reg;

endmodule

/* rtl/pgfs_back.sv */
// ---------------------------------------------------------------------------
// pgfs_back
// expands each queued descriptor into its run of buffer commands
// ---------------------------------------------------------------------------
module pgfs_back import pgfs_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  desc_t        head,
    input  fifo_status_t fifo_st,
    output logic         pop,
    pgfs_cmd_if.source   cmd
);

    logic [1:0]          step_reg, step_next;
    logic                out_valid_reg;
    action_t             act_reg;
    logic [BUFIDX_W-1:0] bidx_reg;
    logic [OFFSET_W-1:0] off_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic [SOURCE_W-1:0] src_reg;
    logic [MISSED_W-1:0] missed_reg;
    logic                last_reg;

    logic                load;
    action_t             act;
    logic [BUFIDX_W-1:0] bidx;
    logic [OFFSET_W-1:0] off;
    logic [COUNT_W-1:0]  cnt;
    logic                is_last;

    assign load = !fifo_st.empty && (!out_valid_reg || cmd.ready);

    // command for the current step of the head descriptor
    always_comb
    begin
        act     = ACT_DROP;
        bidx    = head.buf_idx;
        off     = '0;
        cnt     = '0;
        is_last = 1'b1;
        unique case (head.kind)
            K_WRITE:
            begin
                act = ACT_WRITE;
                off = head.offset;
                cnt = head.count_a;
            end
            K_WRITE_FULL:
            begin
                if (step_reg == 2'd0)
                begin
                    act     = ACT_WRITE;
                    off     = head.offset;
                    cnt     = head.count_a;
                    is_last = 1'b0;
                end
                else
                begin
                    act = ACT_FULL;
                end
            end
            K_FILL:
            begin
                act = ACT_FILL;
                off = head.offset;
                cnt = head.count_a;
            end
            K_FILL_FULL:
            begin
                if (step_reg == 2'd0)
                begin
                    act     = ACT_FILL;
                    off     = head.offset;
                    cnt     = head.count_a;
                    is_last = 1'b0;
                end
                else
                begin
                    act = ACT_FULL;
                end
            end
            K_FILL_FULL_FILL:
            begin
                if (step_reg == 2'd0)
                begin
                    act     = ACT_FILL;
                    off     = head.offset;
                    cnt     = head.count_a;
                    is_last = 1'b0;
                end
                else if (step_reg == 2'd1)
                begin
                    act     = ACT_FULL;
                    is_last = 1'b0;
                end
                else
                begin
                    act  = ACT_FILL;
                    bidx = head.next_buf;
                    cnt  = head.count_b;
                end
            end
            K_GAP:
            begin
                act = ACT_GAP;
                off = head.offset;
            end
            K_DROP:
            begin
                act = ACT_DROP;
            end
            default:
            begin
                act = ACT_DROP;
            end
        endcase
    end

    assign pop = load && is_last;

    always_comb
    begin
        step_next = step_reg;
        if (load)
        begin
            step_next = is_last ? 2'd0 : step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            act_reg    <= act;
            bidx_reg   <= bidx;
            off_reg    <= off;
            cnt_reg    <= cnt;
            src_reg    <= head.source;
            missed_reg <= head.missed;
            last_reg   <= is_last;
        end
    end

    // source byte: adc, multibeam, five beam bits, cross
    assign cmd.valid        = out_valid_reg;
    assign cmd.action       = act_reg;
    assign cmd.buffer_index = bidx_reg;
    assign cmd.slot_offset  = off_reg;
    assign cmd.slot_count   = cnt_reg;
    assign cmd.beam_number  = src_reg[BEAM_W:1];
    assign cmd.cross_term   = src_reg[0];
    assign cmd.adc_source   = src_reg[SOURCE_W-1];
    assign cmd.multi_beam   = src_reg[SOURCE_W-2];
    assign cmd.missed_total = missed_reg;
    assign cmd.last         = last_reg;

endmodule

/* rtl/packet_gap_fill_sequencer.sv */
// ---------------------------------------------------------------------------
// packet_gap_fill_sequencer
// turns spectrometer packet headers into buffer write, zero-fill and
// buffer-full commands, repairing counter gaps up to the next spectrum edge
// ---------------------------------------------------------------------------
//
//  channel  side    handshake     carries
//  -------  ------  ------------  ----------------------------------------------
//  hdr      sink    valid/ready   packet_counter, source_byte
//  cmd      source  valid/ready   action, buffer_index, slot_offset, slot_count,
//                                 beam_number, cross_term, adc_source,
//                                 multi_beam, missed_total, last
//
//  a header passes three front stages (decode, classify, accounting) and
//  the descriptor queue before it reaches the command register
//  the command stage issues one command per cycle while a descriptor waits and
//  cmd.ready allows; a header gives one command for a write, fill, drop or gap,
//  two with a buffer full, three for a crossing fill; it sets the sustained rate
//  hdr.ready drops only once the eight-entry descriptor queue, counting the
//  headers still in the front stages, is spoken for
//  reset clears the sequence state and the queue at once, no clearing pass
//
module packet_gap_fill_sequencer import pgfs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    pgfs_hdr_if.sink   hdr,
    pgfs_cmd_if.source cmd
);

    // front to queue
    logic         push;
    desc_t        push_desc;

    // queue to back
    desc_t        head;
    logic         pop;
    fifo_status_t fifo_st;

    // classify headers and track the expected counter, slot and buffer
    pgfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr       (hdr),
        .fifo_st   (fifo_st),
        .push      (push),
        .push_desc (push_desc)
    );

    // decouples header intake from command issue
    pgfs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .status    (fifo_st)
    );

    // expand descriptors into commands behind an output register
    pgfs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .fifo_st (fifo_st),
        .pop     (pop),
        .cmd     (cmd)
    );

endmodule

/* rtl/pgfs_checker.sv */
// ---------------------------------------------------------------------------
// pgfs_checker
// port-level checks on the command stream of the sequencer
// ---------------------------------------------------------------------------
`include "packet_gap_fill_sequencer_macros.svh"

module pgfs_checker import pgfs_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic [ACTION_W-1:0] cmd_action,
    input logic [OFFSET_W-1:0] cmd_slot_offset,
    input logic [COUNT_W-1:0]  cmd_slot_count,
    input logic [MISSED_W-1:0] cmd_missed_total,
    input logic                cmd_last
);

    // a stalled command holds
    `PGFS_ASSERT_NXT(a_cmd_hold, clk, rst_n, cmd_valid && !cmd_ready, cmd_valid && $stable(cmd_action) && $stable(cmd_slot_count) && $stable(cmd_last), "command changed under stall")

    // buffer full carries no span
    `PGFS_ASSERT_IMP(a_full_empty, clk, rst_n, cmd_valid && (cmd_action == ACT_FULL), (cmd_slot_offset == '0) && (cmd_slot_count == '0), "buffer full with span")

    // a payload write covers one slot
    `PGFS_ASSERT_IMP(a_write_one, clk, rst_n, cmd_valid && (cmd_action == ACT_WRITE), cmd_slot_count == COUNT_W'(1), "write not one slot")

    // drop and gap too large end their header
    `PGFS_ASSERT_IMP(a_single_end, clk, rst_n, cmd_valid && ((cmd_action == ACT_DROP) || (cmd_action == ACT_GAP)), cmd_last, "drop or gap not last")

    // commands of one header share the missed total
    `PGFS_ASSERT_NXT(a_missed_run, clk, rst_n, cmd_valid && cmd_ready && !cmd_last, !cmd_valid || (cmd_missed_total == $past(cmd_missed_total)), "missed total moved within a header")

endmodule

bind packet_gap_fill_sequencer pgfs_checker u_pgfs_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .cmd_action       (cmd.action),
    .cmd_slot_offset  (cmd.slot_offset),
    .cmd_slot_count   (cmd.slot_count),
    .cmd_missed_total (cmd.missed_total),
    .cmd_last         (cmd.last)
);

/* dv/packet_gap_fill_sequencer_test.sv */
// ---------------------------------------------------------------------------
// packet_gap_fill_sequencer_test
// self-checking bench for the gap-fill sequencer: headers go in on the hdr
// channel, every command on the cmd channel is checked field by field
// against a cycle-free predictor of the sequence state
// ---------------------------------------------------------------------------
module packet_gap_fill_sequencer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pgfs_pkg::*;

    // run limits
    localparam int unsigned RANDOM_HEADERS = 250;
    localparam int unsigned DRAIN_CYCLES   = 32;
    localparam int unsigned STALL_LIMIT    = 2000;

    // one expected command on the cmd channel
    typedef struct {
        action_t             action;
        logic [BUFIDX_W-1:0] buffer_index;
        logic [OFFSET_W-1:0] slot_offset;
        logic [COUNT_W-1:0]  slot_count;
        logic [BEAM_W-1:0]   beam_number;
        logic                cross_term;
        logic                adc_source;
        logic                multi_beam;
        logic [MISSED_W-1:0] missed_total;
        logic                last;
    } buf_cmd_t;

    // ready patterns of the command receiver
    typedef enum int unsigned {
        READY_ALWAYS,
        READY_RANDOM,
        READY_ALTERNATE,
        READY_BURSTY
    } stall_mode_t;

    logic clk;
    logic rst_n;

    pgfs_hdr_if hdr ();
    pgfs_cmd_if cmd ();

    packet_gap_fill_sequencer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr),
        .cmd   (cmd)
    );

    // predicted sequence state, updated at each header transfer
    logic [COUNTER_W-1:0] next_counter;
    int unsigned          fill_slot;
    int unsigned          active_buf;
    logic                 mid_spectrum;
    logic                 seen_first;
    logic [MISSED_W-1:0]  lost_packets;

    // commands still owed by the block, oldest first
    buf_cmd_t    pending_cmds[$];
    int unsigned mismatches;

    // sender pacing
    int unsigned burst_left;
    logic        sender_gaps;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // predictor
    // -----------------------------------------------------------------------

    function automatic buf_cmd_t make_cmd(input action_t act, input int unsigned bufno,
                                          input longint unsigned off,
                                          input longint unsigned cnt,
                                          input logic [SOURCE_W-1:0] src);
        buf_cmd_t c;
        c.action       = act;
        c.buffer_index = bufno[BUFIDX_W-1:0];
        c.slot_offset  = off[OFFSET_W-1:0];
        c.slot_count   = cnt[COUNT_W-1:0];
        // source byte: adc, multibeam, five beam bits, cross
        c.adc_source   = src[7];
        c.multi_beam   = src[6];
        c.beam_number  = src[5:1];
        c.cross_term   = src[0];
        c.missed_total = '0;
        c.last         = 1'b0;
        return c;
    endfunction

    function automatic void advance_buffer();
        active_buf = (active_buf + 1) % NUM_BUFFERS;
        fill_slot  = 0;
    endfunction

    // works out the command run of one header and queues it
    function automatic void predict_commands(input logic [COUNTER_W-1:0] cnt,
                                             input logic [SOURCE_W-1:0] src);
        buf_cmd_t             run[$];
        logic [COUNTER_W-1:0] gap;
        longint unsigned      span;
        longint unsigned      room;
        int unsigned          pos;
        int unsigned          rest;

        pos = 32'(cnt % COUNTER_W'(PKTS_PER_SPECTRUM));

        if (pos == 0 || mid_spectrum)
        begin
            // the first header that gets past the drop rule sets the count
            if (!seen_first)
            begin
                next_counter = cnt;
                seen_first   = 1'b1;
            end

            if (next_counter == cnt)
            begin
                run.push_back(make_cmd(ACT_WRITE, active_buf, fill_slot, 1, src));
                fill_slot++;
                mid_spectrum = 1'b1;
                next_counter = next_counter + 1'b1;
                if (fill_slot >= SLOTS_PER_BUFFER)
                begin
                    run.push_back(make_cmd(ACT_FULL, active_buf, 0, 0, src));
                    advance_buffer();
                    mid_spectrum = 1'b0;
                end
            end
            else
            begin
                // difference wraps in 56 bits, so a counter behind is a huge gap
                gap  = cnt - next_counter;
                span = 64'(gap) + 64'(PKTS_PER_SPECTRUM) - 64'(pos);
                room = 64'(SLOTS_PER_BUFFER) - 64'(fill_slot);

                // saturating lost-packet total
                if (64'(gap) >= 64'(32'hffff_ffff - lost_packets))
                    lost_packets = '1;
                else
                    lost_packets = lost_packets + gap[MISSED_W-1:0];

                if (span < room)
                begin
                    run.push_back(make_cmd(ACT_FILL, active_buf, fill_slot, span, src));
                    fill_slot += int'(span);
                end
                else if (span <= 64'(SLOTS_PER_BUFFER))
                begin
                    // fill to the end, mark full, carry the rest into the next buffer
                    rest = int'(span - room);
                    run.push_back(make_cmd(ACT_FILL, active_buf, fill_slot, room, src));
                    run.push_back(make_cmd(ACT_FULL, active_buf, 0, 0, src));
                    advance_buffer();
                    if (rest > 0)
                    begin
                        run.push_back(make_cmd(ACT_FILL, active_buf, 0, rest, src));
                        fill_slot = rest;
                    end
                end
                else
                begin
                    run.push_back(make_cmd(ACT_GAP, active_buf, fill_slot, 0, src));
                end

                // realign on the next spectrum boundary after this packet
                next_counter = cnt + PKTS_PER_SPECTRUM - pos;
                mid_spectrum = 1'b0;
            end
        end
        else
        begin
            run.push_back(make_cmd(ACT_DROP, active_buf, 0, 0, src));
        end

        foreach (run[i])
        begin
            run[i].missed_total = lost_packets;
            run[i].last         = (i == run.size() - 1);
            pending_cmds.push_back(run[i]);
        end
    endfunction

    // -----------------------------------------------------------------------
    // header sender
    // -----------------------------------------------------------------------

    // drives one header, holds it until the transfer, then predicts its commands
    task automatic send_header(input logic [COUNTER_W-1:0] cnt,
                               input logic [SOURCE_W-1:0] src);
        if (burst_left == 0)
        begin
            if (sender_gaps)
            begin
                hdr.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;

        hdr.valid          <= 1'b1;
        hdr.packet_counter <= cnt;
        hdr.source_byte    <= src;
        do
            @(posedge clk);
        while (!hdr.ready);
        predict_commands(cnt, src);
    endtask

    // next spectrum boundary at or after the expected counter
    function automatic logic [COUNTER_W-1:0] boundary_ahead();
        return next_counter + (PKTS_PER_SPECTRUM - next_counter % PKTS_PER_SPECTRUM)
                              % PKTS_PER_SPECTRUM;
    endfunction

    // -----------------------------------------------------------------------
    // command receiver and checker
    // -----------------------------------------------------------------------

    // receiver stalls follow a pattern picked anew at random from four ready modes
    initial
    begin : ready_pattern
        stall_mode_t mode;
        int unsigned tick;
        mode      = READY_ALWAYS;
        tick      = 0;
        cmd.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (tick % 64 == 0)
                mode = stall_mode_t'($urandom_range(0, 3));
            unique case (mode)
                READY_ALWAYS:    cmd.ready <= 1'b1;
                READY_RANDOM:    cmd.ready <= ($urandom_range(0, 3) != 0);
                READY_ALTERNATE: cmd.ready <= tick[0];
                READY_BURSTY:    cmd.ready <= (tick % 8 >= 5);
                default:         cmd.ready <= 1'b1;
            endcase
            tick++;
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // each command transfer is checked against the oldest expectation
    always @(posedge clk)
    begin : command_check
        buf_cmd_t want;
        if (rst_n && cmd.valid && cmd.ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $error("command transfer with nothing expected: action %0d", cmd.action);
                mismatches++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                check_field("action",       want.action,       cmd.action);
                check_field("buffer_index", want.buffer_index, cmd.buffer_index);
                check_field("slot_offset",  want.slot_offset,  cmd.slot_offset);
                check_field("slot_count",   want.slot_count,   cmd.slot_count);
                check_field("beam_number",  want.beam_number,  cmd.beam_number);
                check_field("cross_term",   want.cross_term,   cmd.cross_term);
                check_field("adc_source",   want.adc_source,   cmd.adc_source);
                check_field("multi_beam",   want.multi_beam,   cmd.multi_beam);
                check_field("missed_total", want.missed_total, cmd.missed_total);
                check_field("last",         want.last,         cmd.last);
            end
        end
    end

    // ends the run when neither channel has moved for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (hdr.valid && hdr.ready) || (cmd.valid && cmd.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // -----------------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------------

    // drop before the first spectrum, start near the top of the counter,
    // wrap to zero, a small gap inside a spectrum and a drop after it
    task automatic test_start_and_wrap();
        send_header(56'hff_ffff_ffff_ffff, 8'hff);  // odd position, nothing started
        send_header(56'hff_ffff_ffff_fffe, 8'h00);  // first write loads the count
        send_header(56'hff_ffff_ffff_ffff, 8'haa);
        send_header(56'd0, 8'h55);                  // counter has wrapped
        send_header(56'd1, 8'($urandom));
        send_header(56'd5, 8'($urandom));           // gap mid spectrum, fill of four
        send_header(56'd7, 8'($urandom));           // odd position outside a spectrum
        send_header(56'd6, 8'($urandom));
    endtask

    // fills that end on the buffer edge, cross it, are too large, and a full
    // buffer reached by writes; buffer index runs all the way round
    task automatic test_buffer_crossing();
        send_header(56'd1021, 8'($urandom));  // fill ends exactly at the buffer end
        send_header(56'd1022, 8'($urandom));
        send_header(56'd1623, 8'($urandom));  // fill inside one buffer
        send_header(56'd1624, 8'($urandom));
        send_header(56'd2125, 8'($urandom));  // fill, full, fill in the next buffer
        send_header(56'd4126, 8'($urandom));  // span beyond a buffer
        send_header(56'd4128, 8'($urandom));
        send_header(56'd5069, 8'($urandom));  // fill up to the last two slots
        send_header(56'd5070, 8'($urandom));
        send_header(56'd5071, 8'($urandom));  // write into the last slot, buffer full
        send_header(56'd6094, 8'($urandom));  // whole-buffer fill, wraps to buffer 0
        send_header(56'd6096, 8'($urandom));
    endtask

    // mostly in-order runs with gaps of every size, some stray headers
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned pick;
        int unsigned run_len;
        int unsigned dist_to_end;
        sent = 0;
        while (sent < RANDOM_HEADERS)
        begin
            if ($urandom_range(0, 19) == 0)
                sender_gaps = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // in-order packets
                run_len = $urandom_range(1, 6);
                repeat (run_len) send_header(next_counter, 8'($urandom));
                sent += run_len;
            end
            else if (pick < 80)
            begin
                // a few packets lost
                send_header(next_counter + $urandom_range(1, 6), 8'($urandom));
                sent++;
            end
            else if (pick < 90)
            begin
                // large loss: a long fill, a crossing or too large
                send_header(next_counter + $urandom_range(100, 1100), 8'($urandom));
                sent++;
            end
            else if (pick < 95)
            begin
                // loss that lands near the end of the buffer
                dist_to_end = SLOTS_PER_BUFFER - fill_slot + $urandom_range(0, 2);
                dist_to_end = (dist_to_end > 1) ? dist_to_end - 1 : 1;
                send_header(next_counter + dist_to_end, 8'($urandom));
                sent++;
            end
            else
            begin
                // one past the expected count: a drop outside a spectrum, a small fill inside one
                send_header(next_counter + 1'b1, 8'($urandom));
                sent++;
            end
        end
        sender_gaps = 1'b1;
    endtask

    // lost total up to one below saturation, then saturation, a counter
    // behind the expected one, and headers with arbitrary counters
    task automatic test_lost_count_saturation();
        // get inside a spectrum so any position is taken
        do
            send_header(boundary_ahead(), 8'($urandom));
        while (!mid_spectrum);
        if (lost_packets < 32'hffff_fffe)
            send_header(next_counter + (32'hffff_fffe - lost_packets), 8'($urandom));
        send_header(next_counter + PKTS_PER_SPECTRUM, 8'($urandom));
        send_header(next_counter - PKTS_PER_SPECTRUM, 8'($urandom));
        repeat (8) send_header(COUNTER_W'({$urandom, $urandom}), 8'($urandom));
    endtask

    // -----------------------------------------------------------------------
    // sequence
    // -----------------------------------------------------------------------

    initial
    begin
        next_counter       = '0;
        fill_slot          = 0;
        active_buf         = 0;
        mid_spectrum       = 1'b0;
        seen_first         = 1'b0;
        lost_packets       = '0;
        mismatches         = 0;
        burst_left         = 0;
        sender_gaps        = 1'b1;
        hdr.valid          = 1'b0;
        hdr.packet_counter = '0;
        hdr.source_byte    = '0;
        rst_n              = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_start_and_wrap();
        test_buffer_crossing();
        test_random_traffic();
        test_lost_count_saturation();

        hdr.valid <= 1'b0;
        // wait for every owed command, then give stray ones time to show
        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
